// File: sv/gcd2m_pkg.sv
package gcd2m_pkg;

  // Default operand width
  localparam int unsigned DATA_WIDTH = 31;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_STRIP_COMMON,
    S_STRIP,
    S_SUB,
    S_UPDATE,
    S_FINISH
  } state_e;

  // Outcome of one serial subtraction pass
  typedef struct packed {
    logic x_lt_y;
    logic equal;
  } sub_status_t;

endpackage

// File: sv/gcd2m_sersub.sv
module gcd2m_sersub (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    first_i,
  input  logic                    x_bit_i,
  input  logic                    y_bit_i,
  output logic                    xy_bit_o,
  output logic                    yx_bit_o,
  output gcd2m_pkg::sub_status_t  status_o
);
  import gcd2m_pkg::*;

  logic bxy_q, bxy_d;
  logic byx_q, byx_d;
  logic neq_q, neq_d;
  logic bxy_in, byx_in, neq_in;
  logic bit_eq;

  // Start each pass with no borrow and nothing seen
  assign bxy_in = first_i ? 1'b0 : bxy_q;
  assign byx_in = first_i ? 1'b0 : byx_q;
  assign neq_in = first_i ? 1'b0 : neq_q;
  assign bit_eq = ~(x_bit_i ^ y_bit_i);

  // Form one bit of x - y and of y - x, LSB first
  always_comb begin
    xy_bit_o = x_bit_i ^ y_bit_i ^ bxy_in;
    yx_bit_o = x_bit_i ^ y_bit_i ^ byx_in;
    bxy_d    = (~x_bit_i & y_bit_i) | (bit_eq & bxy_in);
    byx_d    = (~y_bit_i & x_bit_i) | (bit_eq & byx_in);
    neq_d    = neq_in | xy_bit_o;
  end

  // Hold borrows and the nonzero flag between bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bxy_q <= 1'b0;
      byx_q <= 1'b0;
      neq_q <= 1'b0;
    end else if (en_i) begin
      bxy_q <= bxy_d;
      byx_q <= byx_d;
      neq_q <= neq_d;
    end
  end

  // A final borrow of x - y means x < y
  assign status_o.x_lt_y = bxy_q;
  assign status_o.equal  = ~neq_q;

endmodule

// File: sv/gcd_euclid_two_mode.sv
// Greatest common divisor of two unsigned operands, computed with a bit-serial
// subtractor: every compare-and-subtract streams both operands LSB first
// through one full-subtractor cell, so a pass streams all DataWidth bits and
// then updates the larger operand. With use_remainder_i high the block runs
// binary steps (drop shared and single factors of two one bit per cycle, then
// subtract). With use_remainder_i low it runs plain Euclidean subtraction: the
// number of subtractions is the sum of the quotients, up to about 2^DataWidth
// for very unbalanced operands. A zero operand returns the other operand. One
// transaction is worked at a time; the result sits in an output register, so
// the next transaction is taken while the previous result waits for
// out_ready_i.
module gcd_euclid_two_mode #(
  parameter int unsigned DataWidth = gcd2m_pkg::DATA_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [DataWidth-1:0] operand_a_i,
  input  logic [DataWidth-1:0] operand_b_i,
  input  logic                 use_remainder_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DataWidth-1:0] divisor_o
);
  import gcd2m_pkg::*;

  localparam int unsigned CntW = $clog2(DataWidth);
  localparam logic [CntW-1:0] LastCnt = CntW'(DataWidth - 1);

  state_e state_q, state_d;

  logic [DataWidth-1:0] x_q, x_d;
  logic [DataWidth-1:0] y_q, y_d;
  logic [DataWidth-1:0] dxy_q, dxy_d;
  logic [DataWidth-1:0] dyx_q, dyx_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW-1:0]      twos_q, twos_d;
  logic                 binary_q, binary_d;
  logic [DataWidth-1:0] res_q, res_d;
  logic                 res_valid_q, res_valid_d;

  logic        in_fire;
  logic        zero_in;
  logic        res_free;
  logic        sub_en;
  logic        sub_first;
  logic        xy_bit, yx_bit;
  sub_status_t sub_status;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign zero_in     = (operand_a_i == '0) | (operand_b_i == '0);
  assign res_free    = ~res_valid_q | out_ready_i;
  assign out_valid_o = res_valid_q;
  assign divisor_o   = res_q;

  assign sub_en    = (state_q == S_SUB);
  assign sub_first = (cnt_q == '0);

  gcd2m_sersub u_sersub (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (sub_en),
    .first_i  (sub_first),
    .x_bit_i  (x_q[0]),
    .y_bit_i  (y_q[0]),
    .xy_bit_o (xy_bit),
    .yx_bit_o (yx_bit),
    .status_o (sub_status)
  );

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (zero_in) begin
            state_d = S_FINISH;
          end else if (use_remainder_i) begin
            state_d = S_STRIP_COMMON;
          end else begin
            state_d = S_SUB;
          end
        end
      end
      S_STRIP_COMMON: begin
        if (x_q[0] | y_q[0]) begin
          state_d = S_STRIP;
        end
      end
      S_STRIP: begin
        if (x_q[0] & y_q[0]) begin
          state_d = S_SUB;
        end
      end
      S_SUB: begin
        if (cnt_q == LastCnt) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (sub_status.equal) begin
          state_d = S_FINISH;
        end else if (binary_q) begin
          state_d = S_STRIP;
        end else begin
          state_d = S_SUB;
        end
      end
      S_FINISH: begin
        if (twos_q == '0 && res_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Drive the datapath for each state
  always_comb begin
    x_d         = x_q;
    y_d         = y_q;
    dxy_d       = dxy_q;
    dyx_d       = dyx_q;
    cnt_d       = cnt_q;
    twos_d      = twos_q;
    binary_d    = binary_q;
    res_d       = res_q;
    res_valid_d = res_valid_q & ~out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          x_d      = zero_in ? (operand_a_i | operand_b_i) : operand_a_i;
          y_d      = operand_b_i;
          cnt_d    = '0;
          twos_d   = '0;
          binary_d = use_remainder_i;
        end
      end
      S_STRIP_COMMON: begin
        // Drop a factor of two shared by both operands
        if (!(x_q[0] | y_q[0])) begin
          x_d    = {1'b0, x_q[DataWidth-1:1]};
          y_d    = {1'b0, y_q[DataWidth-1:1]};
          twos_d = twos_q + 1'b1;
        end
      end
      S_STRIP: begin
        // Drop a factor of two from whichever operand is even
        if (!x_q[0]) begin
          x_d = {1'b0, x_q[DataWidth-1:1]};
        end
        if (!y_q[0]) begin
          y_d = {1'b0, y_q[DataWidth-1:1]};
        end
        cnt_d = '0;
      end
      S_SUB: begin
        // Rotate operands through the subtractor, collect both differences
        x_d   = {x_q[0], x_q[DataWidth-1:1]};
        y_d   = {y_q[0], y_q[DataWidth-1:1]};
        dxy_d = {xy_bit, dxy_q[DataWidth-1:1]};
        dyx_d = {yx_bit, dyx_q[DataWidth-1:1]};
        cnt_d = (cnt_q == LastCnt) ? '0 : cnt_q + 1'b1;
      end
      S_UPDATE: begin
        // Replace the larger operand by the difference
        if (!sub_status.equal) begin
          if (sub_status.x_lt_y) begin
            y_d = dyx_q;
          end else begin
            x_d = dxy_q;
          end
        end
      end
      S_FINISH: begin
        // Restore shared factors of two, then hand off the result
        if (twos_q != '0) begin
          x_d    = {x_q[DataWidth-2:0], 1'b0};
          twos_d = twos_q - 1'b1;
        end else if (res_free) begin
          res_d       = x_q;
          res_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      cnt_q       <= '0;
      twos_q      <= '0;
      binary_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      cnt_q       <= cnt_d;
      twos_q      <= twos_d;
      binary_q    <= binary_d;
    end
  end

  // Payload shift registers
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    dxy_q <= dxy_d;
    dyx_q <= dyx_d;
    res_q <= res_d;
  end

endmodule

// File: tb/gcd_euclid_two_mode_tb.sv
`timescale 1ns / 1ps

module gcd_euclid_two_mode_tb;
  import gcd2m_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  typedef logic [DW-1:0] word_t;

  localparam word_t WORD_MAX = '1;

  // Mode bit encodings
  localparam logic MODE_SUB = 1'b0;
  localparam logic MODE_REM = 1'b1;

  // Receiver behavior per stretch
  localparam int RX_ALWAYS = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_STALL  = 2;

  // Subtraction mode costs one serial pass per subtraction; keep it bounded
  localparam longint SUB_PASS_CAP = 64;
  localparam int     RANDOM_ITEMS = 350;
  localparam int     DRAIN_CYCLES = 100;
  localparam longint CYCLE_LIMIT  = 6_000_000;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_ready_o;
  word_t operand_a_i;
  word_t operand_b_i;
  logic  use_remainder_i;
  logic  out_valid_o;
  logic  out_ready_i;
  word_t divisor_o;

  longint cycles = 0;

  gcd_euclid_two_mode u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operand_a_i    (operand_a_i),
    .operand_b_i    (operand_b_i),
    .use_remainder_i(use_remainder_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .divisor_o      (divisor_o)
  );

  // Euclid by remainders; a zero operand yields the other one
  function automatic word_t gcd_of(word_t a, word_t b);
    word_t x;
    word_t y;
    x = a;
    y = b;
    while (x != 0 && y != 0) begin
      if (x > y) x = x % y;
      else y = y % x;
    end
    return x + y;
  endfunction

  // Sum of quotients: roughly the number of subtractions in subtraction mode
  function automatic longint sub_passes(word_t a, word_t b);
    word_t  x;
    word_t  y;
    longint n;
    x = a;
    y = b;
    n = 0;
    while (x != 0 && y != 0 && n <= SUB_PASS_CAP) begin
      if (x > y) begin
        n += longint'(x / y);
        x = x % y;
      end else begin
        n += longint'(y / x);
        y = y % x;
      end
    end
    return n;
  endfunction

  class divisor_checker;
    word_t expected_divisors[$];
    int    errors = 0;

    task report_mismatch(string msg);
      $display("gcd mismatch at cycle %0d: %s", cycles, msg);
      errors++;
    endtask

    // Record the expected divisor of an accepted transaction
    task note_operands(word_t a, word_t b);
      expected_divisors = {expected_divisors, gcd_of(a, b)};
    endtask

    // Compare a delivered divisor with the oldest expectation
    task check_divisor(word_t got);
      word_t want;
      if (expected_divisors.size() == 0) begin
        report_mismatch($sformatf("unexpected divisor %0d", got));
      end else begin
        want = expected_divisors.pop_front();
        if (got !== want)
          report_mismatch($sformatf("divisor %0d, expected %0d", got, want));
      end
    endtask

    function int pending();
      return expected_divisors.size();
    endfunction
  endclass

  divisor_checker sb = new();

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Count cycles and abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("gcd_euclid_two_mode_tb: errors");
      $finish;
    end
  end

  // Check every delivered result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_divisor(divisor_o);
  end

  // Receiver: stretches of steady ready, random ready and full stall
  initial begin
    int kind;
    int len;
    out_ready_i = 1'b0;
    forever begin
      kind = $urandom_range(RX_ALWAYS, RX_STALL);
      len  = $urandom_range(1, 40);
      repeat (len) begin
        @(negedge clk_i);
        case (kind)
          RX_ALWAYS: out_ready_i <= 1'b1;
          RX_RANDOM: out_ready_i <= 1'($urandom_range(0, 1));
          default:   out_ready_i <= 1'b0;
        endcase
      end
    end
  end

  // Present one transaction and hold it until accepted
  task automatic send_item(word_t a, word_t b, logic mode);
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    operand_a_i     <= a;
    operand_b_i     <= b;
    use_remainder_i <= mode;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_operands(a, b);
  endtask

  // Drop valid for a span given by n; an n of zero leaves valid unchanged
  task automatic hold_off(int n);
    if (n > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Pause the sender until every result is back
  task automatic wait_drained();
    hold_off(1);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Build one random transaction
  function automatic void pick_operands(output word_t a, output word_t b,
                                        output logic mode);
    int    sel;
    int    m;
    int    n;
    int    mx;
    word_t g;
    sel  = $urandom_range(0, 9);
    mode = 1'($urandom_range(0, 1));
    if (sel <= 3) begin
      // common factor times small cofactors
      m  = $urandom_range(0, 63);
      n  = $urandom_range(0, 63);
      mx = (m > n) ? m : n;
      if (mx == 0) mx = 1;
      g  = word_t'($urandom_range(1, 32'(WORD_MAX) / mx));
      a  = word_t'(g * m);
      b  = word_t'(g * n);
    end else if (sel <= 6) begin
      a = word_t'($urandom);
      b = word_t'($urandom);
    end else if (sel == 7) begin
      a = word_t'($urandom) >> $urandom_range(0, DW - 1);
      b = word_t'($urandom) >> $urandom_range(0, DW - 1);
    end else if (sel == 8) begin
      a = word_t'($urandom) >> $urandom_range(0, DW - 1);
      b = '0;
      if ($urandom_range(0, 1)) begin
        b = a;
        a = '0;
      end
    end else begin
      a = word_t'($urandom) >> $urandom_range(0, DW - 1);
      b = a;
    end
    // fall back to remainder steps when subtraction would run too long
    if (mode == MODE_SUB && sub_passes(a, b) > SUB_PASS_CAP) mode = MODE_REM;
  endfunction

  initial begin
    word_t a;
    word_t b;
    logic  mode;
    int    burst_left;

    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    operand_a_i     = '0;
    operand_b_i     = '0;
    use_remainder_i = MODE_SUB;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zeros, extremes, equal operands, powers of two, long chains
    send_item('0, '0, MODE_REM);
    send_item('0, '0, MODE_SUB);
    send_item('0, WORD_MAX, MODE_REM);
    send_item(WORD_MAX, '0, MODE_SUB);
    send_item(word_t'(1), '0, MODE_SUB);
    send_item('0, word_t'(1), MODE_REM);
    send_item(WORD_MAX, WORD_MAX, MODE_SUB);
    send_item(WORD_MAX, WORD_MAX, MODE_REM);
    send_item(WORD_MAX, word_t'(1), MODE_REM);
    send_item(word_t'(1), WORD_MAX, MODE_REM);
    send_item(word_t'(1), word_t'(1), MODE_SUB);
    send_item(word_t'(31'h7FFF_FFFE), word_t'(31'h3FFF_FFFF), MODE_SUB);
    send_item(word_t'(31'h4000_0000), word_t'(31'h2000_0000), MODE_SUB);
    send_item(word_t'(31'h4000_0000), word_t'(31'h0000_0400), MODE_REM);
    send_item(word_t'(12), word_t'(18), MODE_SUB);
    send_item(word_t'(18), word_t'(12), MODE_REM);
    send_item(word_t'(12345), word_t'(12345), MODE_REM);
    send_item(word_t'(2147483629), WORD_MAX, MODE_REM);
    send_item(word_t'(1836311903), word_t'(1134903170), MODE_REM);
    send_item(word_t'(1836311903), word_t'(1134903170), MODE_SUB);
    hold_off($urandom_range(1, 30));
    send_item(word_t'(31'h5555_5555), word_t'(31'h2AAA_AAAA), MODE_REM);
    wait_drained();

    // Random: bursts of back-to-back transactions with random gaps
    burst_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 7) == 0) hold_off($urandom_range(0, 1500));
        else hold_off($urandom_range(0, 20));
        burst_left = $urandom_range(1, 12);
      end
      if (i == RANDOM_ITEMS / 2) wait_drained();
      pick_operands(a, b, mode);
      send_item(a, b, mode);
      burst_left--;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("gcd_euclid_two_mode_tb: clean");
    end else begin
      $display("gcd_euclid_two_mode_tb: errors");
    end
    $finish;
  end

endmodule
